// ===== src/pwmd_pkg.sv =====
// pwmd_pkg: widths, codes, constants and pipeline token types of the
// rc pulse-width switch decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pwmd_pkg;

    localparam int STAMP_W   = 63;
    localparam int WIDTH_W   = 17;
    localparam int THR_W     = 13;
    localparam int CFG_IDX_W = 2;

    // nanosecond span that can still give a width below the saturation point
    localparam int DIFF_W = 27;

    localparam int NS_PER_US      = 1000;
    localparam int WIDTH_LIMIT_US = 100000;
    // smallest span whose width exceeds the limit: (limit + 1) * 1000
    localparam int SAT_NS         = (WIDTH_LIMIT_US + 1) * NS_PER_US;

    // floor(2^37 / 1000): quotient is exact or one low for spans below 2^27
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 28'd137438953;
    localparam int PROD_W      = DIFF_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [THR_W-1:0] ON_THR_RST    = 13'd1700;
    localparam logic [THR_W-1:0] OFF_THR_RST   = 13'd1300;
    localparam logic [THR_W-1:0] MIN_VALID_RST = 13'd900;
    localparam logic [THR_W-1:0] MAX_VALID_RST = 13'd2100;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_THR    = 2'd0,
        CFG_OFF_THR   = 2'd1,
        CFG_MIN_VALID = 2'd2,
        CFG_MAX_VALID = 2'd3
    } cfg_idx_t;

    // measured span leaving the edge stage
    typedef struct packed {
        logic              clear;
        logic              sat;
        logic [DIFF_W-1:0] diff;
    } pwmd_diff_t;

    // span with its estimated quotient
    typedef struct packed {
        logic              clear;
        logic              sat;
        logic [DIFF_W-1:0] diff;
        logic [QUOT_W-1:0] quot;
    } pwmd_quot_t;

    // finished width in microseconds
    typedef struct packed {
        logic               clear;
        logic [WIDTH_W-1:0] width;
    } pwmd_width_t;

endpackage

`default_nettype wire

// ===== src/pwmd_if.sv =====
// pwmd_if: valid/ready channels of the decoder (edge events, results, register writes)
// depends on pwmd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pwmd_evt_if
    import pwmd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic               rising;
    logic [STAMP_W-1:0] stamp_ns;
    logic               seq_gap;

    modport source (output valid, output op, output rising, output stamp_ns,
                    output seq_gap, input ready);
    modport sink   (input valid, input op, input rising, input stamp_ns,
                    input seq_gap, output ready);
endinterface

interface pwmd_res_if
    import pwmd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] width_us;
    logic               width_ok;
    logic               level_on;
    logic               is_locked;

    modport source (output valid, output width_us, output width_ok, output level_on,
                    output is_locked, input ready);
    modport sink   (input valid, input width_us, input width_ok, input level_on,
                    input is_locked, output ready);
endinterface

interface pwmd_cfg_if
    import pwmd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [THR_W-1:0]     data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pwmd_width_pipe.sv =====
// pwmd_width_pipe: two-stage nanosecond-to-microsecond conversion with saturation
// depends on pwmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwmd_width_pipe
    import pwmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire pwmd_diff_t  in_tok,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pwmd_width_t      out_tok
);

    logic        b_valid_reg;
    logic        b_valid_next;
    pwmd_quot_t  b_tok_reg;
    pwmd_quot_t  b_tok_next;
    logic        c_valid_reg;
    logic        c_valid_next;
    pwmd_width_t c_tok_reg;
    pwmd_width_t c_tok_next;

    logic              b_ready;
    logic              c_ready;
    logic [PROD_W-1:0] prod;
    logic [DIFF_W:0]   back_mult;
    logic [DIFF_W:0]   remainder;
    logic [QUOT_W-1:0] quot_fixed;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    // stage b: reciprocal multiply
    always_comb
    begin
        prod = PROD_W'(in_tok.diff) * PROD_W'(RECIP_1000);
        b_tok_next.clear = in_tok.clear;
        b_tok_next.sat   = in_tok.sat;
        b_tok_next.diff  = in_tok.diff;
        b_tok_next.quot  = prod[PROD_W-1:RECIP_SHIFT];
        b_valid_next     = b_ready ? in_valid : b_valid_reg;
    end

    // stage c: one correction step, then saturate
    always_comb
    begin
        back_mult  = (DIFF_W + 1)'(b_tok_reg.quot) * (DIFF_W + 1)'(NS_PER_US);
        remainder  = {1'b0, b_tok_reg.diff} - back_mult;
        quot_fixed = b_tok_reg.quot;
        if (remainder >= (DIFF_W + 1)'(NS_PER_US))
        begin
            quot_fixed = b_tok_reg.quot + QUOT_W'(1);
        end
        c_tok_next.clear = b_tok_reg.clear;
        if (b_tok_reg.sat)
        begin
            c_tok_next.width = WIDTH_W'(WIDTH_LIMIT_US);
        end
        else
        begin
            c_tok_next.width = quot_fixed[WIDTH_W-1:0];
        end
        c_valid_next = c_ready ? b_valid_reg : c_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_tok_reg <= b_tok_next;
        end
        if (c_ready)
        begin
            c_tok_reg <= c_tok_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_tok   = c_tok_reg;

endmodule

`default_nettype wire

// ===== src/pwm_pulse_width_switch_decoder_unit.sv =====
// pwm_pulse_width_switch_decoder_unit: top level of the rc pulse-width switch decoder
// depends on pwmd_pkg, pwmd_if and pwmd_width_pipe
`timescale 1ns / 1ps
`default_nettype none

// Decodes timestamped edges of an rc-style pwm line into a switch level. Each
// edge transaction on evt is taken, and a new one can follow, in every cycle in
// which the edge register is empty or hands its token on; a falling edge that
// closes a recorded rise gives one result transaction on res after it passes
// the edge register, multiply stage, correction stage and result register, while
// rising edges, orphan falls and clear ops give none. The sustained rate
// is one transaction per cycle and is set by the result register: it stalls
// only while a result waits and res.ready is low, and since every stage has
// its own ready the pipe keeps filling behind it.
// The width is (fall - rise) / 1000 in microseconds, saturated at 100000,
// and 0 if the fall is stamped before its rise. A width within
// min_valid_us..max_valid_us moves the level with hysteresis (the on test
// wins; direction follows which threshold is larger) and counts toward lock
// at PULSES_TO_LOCK; any other width clears lock count and level. A seq_gap
// edge first drops the pending rise. Register writes on cfg are taken in any
// cycle and each clears the decoder state; the user must write only while the
// block is idle, which it does not enforce. No clearing pass follows reset.
module pwm_pulse_width_switch_decoder_unit
    import pwmd_pkg::*;
#(
    parameter int PULSES_TO_LOCK = 3
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pwmd_evt_if.sink   evt,
    pwmd_res_if.source res,
    pwmd_cfg_if.sink   cfg
);

    localparam int CountW = $clog2(PULSES_TO_LOCK + 1);
    localparam logic [CountW-1:0] LockCount = CountW'(PULSES_TO_LOCK);

    // configuration registers
    logic [THR_W-1:0] on_thr_reg;
    logic [THR_W-1:0] off_thr_reg;
    logic [THR_W-1:0] min_valid_reg;
    logic [THR_W-1:0] max_valid_reg;

    // edge stage state
    logic               rise_pending_reg;
    logic               rise_pending_next;
    logic [STAMP_W-1:0] rise_stamp_reg;
    logic [STAMP_W-1:0] rise_stamp_next;
    logic               a_valid_reg;
    logic               a_valid_next;
    pwmd_diff_t         a_tok_reg;
    pwmd_diff_t         a_tok_next;
    logic               a_load;

    // decoder state and result register
    logic [CountW-1:0]  count_reg;
    logic [CountW-1:0]  count_next;
    logic               level_reg;
    logic               level_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [WIDTH_W-1:0] res_width_reg;
    logic               res_ok_reg;
    logic               res_ok_next;
    logic               res_level_reg;
    logic               res_lock_reg;

    logic               evt_fire;
    logic               cfg_fire;
    logic [STAMP_W:0]   span;
    logic               span_neg;
    logic               span_sat;

    logic               pipe_in_ready;
    logic               pipe_out_valid;
    logic               pipe_out_ready;
    pwmd_width_t        pipe_out_tok;
    logic               d_fire;
    logic               d_load;

    // thresholds widened to the width scale
    logic [WIDTH_W-1:0] on_w;
    logic [WIDTH_W-1:0] off_w;
    logic [WIDTH_W-1:0] min_w;
    logic [WIDTH_W-1:0] max_w;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // edge stage hands off to the pipe, so it takes a new event whenever it drains
    assign evt.ready = !a_valid_reg || pipe_in_ready;
    assign evt_fire  = evt.valid && evt.ready;

    // span since the recorded rise; negative means the fall came first
    assign span     = {1'b0, evt.stamp_ns} - {1'b0, rise_stamp_reg};
    assign span_neg = span[STAMP_W];
    assign span_sat = !span_neg && (span[STAMP_W-1:0] >= STAMP_W'(SAT_NS));

    // edge stage: rise bookkeeping and token launch
    always_comb
    begin
        rise_pending_next = rise_pending_reg;
        rise_stamp_next   = rise_stamp_reg;
        a_tok_next        = a_tok_reg;
        a_load            = 1'b0;
        if (cfg_fire)
        begin
            rise_pending_next = 1'b0;
        end
        else if (evt_fire)
        begin
            if (evt.op == OP_CLEAR)
            begin
                // clear travels down the pipe so that count and level clear in order
                rise_pending_next = 1'b0;
                a_load            = 1'b1;
                a_tok_next.clear  = 1'b1;
                a_tok_next.sat    = 1'b0;
                a_tok_next.diff   = '0;
            end
            else if (evt.rising)
            begin
                rise_pending_next = 1'b1;
                rise_stamp_next   = evt.stamp_ns;
            end
            else
            begin
                // a fall always leaves no rise pending; it measures only a valid rise
                rise_pending_next = 1'b0;
                if (rise_pending_reg && !evt.seq_gap)
                begin
                    a_load           = 1'b1;
                    a_tok_next.clear = 1'b0;
                    a_tok_next.sat   = span_sat;
                    a_tok_next.diff  = span_neg ? '0 : span[DIFF_W-1:0];
                end
            end
        end
        if (a_load)
        begin
            a_valid_next = 1'b1;
        end
        else if (pipe_in_ready)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    pwmd_width_pipe u_width_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (pipe_in_ready),
        .in_tok    (a_tok_reg),
        .out_valid (pipe_out_valid),
        .out_ready (pipe_out_ready),
        .out_tok   (pipe_out_tok)
    );

    // a clear token never needs the result register
    assign pipe_out_ready = pipe_out_tok.clear || !res_valid_reg || res.ready;
    assign d_fire         = pipe_out_valid && pipe_out_ready;
    assign d_load         = d_fire && !pipe_out_tok.clear;

    assign on_w  = WIDTH_W'(on_thr_reg);
    assign off_w = WIDTH_W'(off_thr_reg);
    assign min_w = WIDTH_W'(min_valid_reg);
    assign max_w = WIDTH_W'(max_valid_reg);

    // result stage: validity, hysteresis and lock count
    always_comb
    begin
        count_next  = count_reg;
        level_next  = level_reg;
        res_ok_next = (pipe_out_tok.width >= min_w) && (pipe_out_tok.width <= max_w);
        if (cfg_fire || (d_fire && pipe_out_tok.clear))
        begin
            count_next = '0;
            level_next = 1'b0;
        end
        else if (d_load)
        begin
            if (!res_ok_next)
            begin
                count_next = '0;
                level_next = 1'b0;
            end
            else
            begin
                if (on_thr_reg > off_thr_reg)
                begin
                    // high pulse means on
                    if (pipe_out_tok.width >= on_w)
                    begin
                        level_next = 1'b1;
                    end
                    else if (pipe_out_tok.width <= off_w)
                    begin
                        level_next = 1'b0;
                    end
                end
                else
                begin
                    // inverted sense: short pulse means on
                    if (pipe_out_tok.width <= on_w)
                    begin
                        level_next = 1'b1;
                    end
                    else if (pipe_out_tok.width >= off_w)
                    begin
                        level_next = 1'b0;
                    end
                end
                if (count_reg < LockCount)
                begin
                    count_next = count_reg + CountW'(1);
                end
            end
        end
        if (d_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_thr_reg       <= ON_THR_RST;
            off_thr_reg      <= OFF_THR_RST;
            min_valid_reg    <= MIN_VALID_RST;
            max_valid_reg    <= MAX_VALID_RST;
            rise_pending_reg <= 1'b0;
            a_valid_reg      <= 1'b0;
            count_reg        <= '0;
            level_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_idx_t'(cfg.idx))
                    CFG_ON_THR:    on_thr_reg    <= cfg.data;
                    CFG_OFF_THR:   off_thr_reg   <= cfg.data;
                    CFG_MIN_VALID: min_valid_reg <= cfg.data;
                    CFG_MAX_VALID: max_valid_reg <= cfg.data;
                    default:       on_thr_reg    <= on_thr_reg;
                endcase
            end
            rise_pending_reg <= rise_pending_next;
            a_valid_reg      <= a_valid_next;
            count_reg        <= count_next;
            level_reg        <= level_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rise_stamp_reg <= rise_stamp_next;
        if (a_load)
        begin
            a_tok_reg <= a_tok_next;
        end
        if (d_load)
        begin
            res_width_reg <= pipe_out_tok.width;
            res_ok_reg    <= res_ok_next;
            res_level_reg <= level_next;
            res_lock_reg  <= (count_next >= LockCount);
        end
    end

    // level and lock as they stood right after the pulse in the result register
    assign res.valid     = res_valid_reg;
    assign res.width_us  = res_width_reg;
    assign res.width_ok  = res_ok_reg;
    assign res.level_on  = res_level_reg;
    assign res.is_locked = res_lock_reg;

endmodule

`default_nettype wire

// ===== src/pwmd_checker.sv =====
// pwmd_checker: port-level assertions on the decoder's result channel, bound to the top level
// depends on pwmd_pkg and pwmd_if
`timescale 1ns / 1ps
`default_nettype none

module pwmd_checker
    import pwmd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pwmd_res_if.source res
);

    // width never exceeds the saturation limit
    a_width_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.width_us <= WIDTH_W'(WIDTH_LIMIT_US)))
        else $error("result width beyond saturation limit");

    // an out-of-range pulse drops both level and lock
    a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.width_ok) |-> (!res.level_on && !res.is_locked))
        else $error("invalid pulse left level or lock set");

    // lock is only reported on a valid pulse
    a_lock_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.is_locked) |-> res.width_ok)
        else $error("lock reported on invalid pulse");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(res.width_us)
            && $stable(res.width_ok) && $stable(res.level_on) && $stable(res.is_locked)))
        else $error("result changed while stalled");

endmodule

bind pwm_pulse_width_switch_decoder_unit pwmd_checker u_pwmd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .res   (res)
);

`default_nettype wire
